/* src/rtt_estimator_with_pto_macros.svh */
// Assertion macros for the RTT estimator checker.
// Needs a signal named clk in the scope of each use.
`ifndef RTT_ESTIMATOR_WITH_PTO_MACROS_SVH
`define RTT_ESTIMATOR_WITH_PTO_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define RTTPTO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rttpto: same-cycle check failed");

// Next-cycle implication, sampled at the rising clock edge.
`define RTTPTO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rttpto: next-cycle check failed");

`endif

/* src/rttpto_pkg.sv */
// Shared types and constants for the RTT estimator with probe timeout.
// No dependencies; imported by every other file except the macros header.
`default_nettype none
package rttpto_pkg;

  localparam int TIME_BITS  = 48;
  localparam int RTT_W      = 32;
  localparam int EST_W      = 26;
  localparam int WIN_W      = 40;
  localparam int ACK_W      = 24;
  localparam int PTO_W      = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [EST_W-1:0] RST_MIN_VALID  = EST_W'(1000);
  localparam logic [EST_W-1:0] RST_MAX_VALID  = EST_W'(60000000);
  localparam logic [WIN_W-1:0] RST_MIN_WINDOW = WIN_W'(10000000);
  localparam logic [ACK_W-1:0] RST_ACK_DELAY  = ACK_W'(25000);
  localparam int               GRANULARITY_US = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALID  = 3'd0,
    REG_MAX_VALID  = 3'd1,
    REG_MIN_WINDOW = 3'd2,
    REG_ACK_DELAY  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RTT_W-1:0]     rtt_sample;
    logic                 first_sample;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] win_begin;
  } in_beat_t;

  typedef struct packed {
    logic             sample_accepted;
    logic [EST_W-1:0] srtt;
    logic [EST_W-1:0] rtt_variance;
    logic [RTT_W-1:0] min_rtt;
    logic [PTO_W-1:0] probe_timeout;
  } out_beat_t;

  typedef struct packed {
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic [EST_W-1:0] min_valid_rtt;
    logic [EST_W-1:0] max_valid_rtt;
    logic [WIN_W-1:0] min_window_length;
    logic [ACK_W-1:0] peer_ack_delay;
  } cfg_regs_t;

  typedef struct packed {
    logic [RTT_W-1:0] rtt_sample;
    logic             first_sample;
    logic             accepted;
    logic             expired;
  } front_beat_t;

  typedef struct packed {
    logic        valid;
    front_beat_t beat;
  } front_stage_t;

endpackage
`default_nettype wire

/* src/rttpto_if.sv */
// Valid/ready channel interfaces for input, result and configuration beats.
// Depends on rttpto_pkg for the payload types.
`default_nettype none
interface rttpto_in_if;
  import rttpto_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rttpto_out_if;
  import rttpto_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rttpto_cfg_if;
  import rttpto_pkg::*;
  logic      valid;
  logic      ready;
  cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rttpto_cfg.sv */
// Configuration register file: four registers written over the cfg channel.
// Depends on rttpto_pkg and rttpto_cfg_if.
`default_nettype none
module rttpto_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rttpto_cfg_if.sink             cfg_ch,
  output rttpto_pkg::cfg_regs_t  regs
);
  import rttpto_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_MIN_VALID:  regs_nxt.min_valid_rtt     = cfg_ch.data.value[EST_W-1:0];
        REG_MAX_VALID:  regs_nxt.max_valid_rtt     = cfg_ch.data.value[EST_W-1:0];
        REG_MIN_WINDOW: regs_nxt.min_window_length = cfg_ch.data.value[WIN_W-1:0];
        REG_ACK_DELAY:  regs_nxt.peer_ack_delay    = cfg_ch.data.value[ACK_W-1:0];
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.min_valid_rtt     <= RST_MIN_VALID;
      regs_r.max_valid_rtt     <= RST_MAX_VALID;
      regs_r.min_window_length <= RST_MIN_WINDOW;
      regs_r.peer_ack_delay    <= RST_ACK_DELAY;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/rttpto_front.sv */
// Input register stage: range check and minimum-window expiry per beat.
// Depends on rttpto_pkg and rttpto_in_if.
`default_nettype none
module rttpto_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rttpto_in_if.sink                 in_ch,
  input  wire rttpto_pkg::cfg_regs_t regs,
  input  wire logic                 take,
  output rttpto_pkg::front_stage_t  stage
);
  import rttpto_pkg::*;

  localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  logic                 vld_r;
  front_beat_t          beat_r;
  front_beat_t          beat_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     elapsed_ext;
  logic [CMP_W-1:0]     window_ext;

  assign in_ch.ready = !vld_r || take;
  assign stage.valid = vld_r;
  assign stage.beat  = beat_r;

  always_comb begin
    elapsed     = in_ch.data.now_time - in_ch.data.win_begin;
    elapsed_ext = CMP_W'(elapsed);
    window_ext  = CMP_W'(regs.min_window_length);
    beat_nxt.rtt_sample   = in_ch.data.rtt_sample;
    beat_nxt.first_sample = in_ch.data.first_sample;
    beat_nxt.accepted     = (in_ch.data.rtt_sample >= RTT_W'(regs.min_valid_rtt)) &&
                            (in_ch.data.rtt_sample <= RTT_W'(regs.max_valid_rtt));
    beat_nxt.expired      = elapsed_ext > window_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      beat_r <= beat_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/rttpto_core.sv */
// Estimator state update and result register: EWMA, windowed minimum, PTO.
// Depends on rttpto_pkg and rttpto_out_if.
`default_nettype none
module rttpto_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rttpto_pkg::front_stage_t stage,
  input  wire rttpto_pkg::cfg_regs_t regs,
  output logic                      take,
  rttpto_out_if.source              out_ch
);
  import rttpto_pkg::*;

  logic             out_vld_r;
  out_beat_t        out_r;
  out_beat_t        out_nxt;
  logic [EST_W-1:0] smoothed_r;
  logic [EST_W-1:0] smoothed_nxt;
  logic [EST_W-1:0] variance_r;
  logic [EST_W-1:0] variance_nxt;
  logic [RTT_W-1:0] minimum_r;
  logic [RTT_W-1:0] minimum_nxt;
  logic             fire;
  logic [EST_W-1:0] sample;
  logic [EST_W-1:0] diff;
  logic [EST_W+2:0] var_sum;
  logic [EST_W+3:0] smo_sum;
  logic [EST_W+1:0] var4;
  logic [EST_W+1:0] var4_floor;
  logic [PTO_W:0]   pto_sum;

  assign take         = !out_vld_r || out_ch.ready;
  assign fire         = stage.valid && take;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  always_comb begin
    sample  = stage.beat.rtt_sample[EST_W-1:0];
    diff    = (smoothed_r > sample) ? (smoothed_r - sample) : (sample - smoothed_r);
    var_sum = (EST_W+3)'(variance_r) + ((EST_W+3)'(variance_r) << 1) + (EST_W+3)'(diff);
    smo_sum = ((EST_W+4)'(smoothed_r) << 3) - (EST_W+4)'(smoothed_r) + (EST_W+4)'(sample);

    smoothed_nxt = smoothed_r;
    variance_nxt = variance_r;
    if (stage.beat.accepted) begin
      if (stage.beat.first_sample) begin
        smoothed_nxt = sample;
        variance_nxt = sample >> 1;
      end else begin
        smoothed_nxt = smo_sum[EST_W+2:3];
        variance_nxt = var_sum[EST_W+1:2];
      end
    end

    priority if (stage.beat.expired) begin
      minimum_nxt = stage.beat.rtt_sample;
    end else if (minimum_r == '0 || stage.beat.rtt_sample < minimum_r) begin
      minimum_nxt = stage.beat.rtt_sample;
    end else begin
      minimum_nxt = minimum_r;
    end

    var4       = {variance_nxt, 2'b00};
    var4_floor = (var4 < (EST_W+2)'(GRANULARITY_US)) ? (EST_W+2)'(GRANULARITY_US) : var4;
    pto_sum    = (PTO_W+1)'(smoothed_nxt) + (PTO_W+1)'(var4_floor) +
                 (PTO_W+1)'(regs.peer_ack_delay);

    out_nxt.sample_accepted = stage.beat.accepted;
    out_nxt.srtt            = smoothed_nxt;
    out_nxt.rtt_variance    = variance_nxt;
    out_nxt.min_rtt         = minimum_nxt;
    out_nxt.probe_timeout   = pto_sum[PTO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      smoothed_r <= '0;
      variance_r <= '0;
      minimum_r  <= '0;
    end else begin
      if (take) begin
        out_vld_r <= stage.valid;
      end
      if (fire) begin
        smoothed_r <= smoothed_nxt;
        variance_r <= variance_nxt;
        minimum_r  <= minimum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/rtt_estimator_with_pto.sv */
// RTT estimator with probe timeout, top level.
// Path: an input beat passes the input register, then the result register, to the result beat.
// Throughput: 1 beat per cycle while out_ch.ready is high; the state feedback closes in the result stage.
// Reset: synchronous active-low rst_n clears state to zero and loads register defaults.
// Depends on rttpto_pkg, rttpto_if, rttpto_cfg, rttpto_front and rttpto_core.
`default_nettype none
module rtt_estimator_with_pto (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rttpto_in_if.sink     in_ch,
  rttpto_out_if.source  out_ch,
  rttpto_cfg_if.sink    cfg_ch
);
  import rttpto_pkg::*;

  cfg_regs_t    regs;
  front_stage_t stage;
  logic         take;

  rttpto_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  rttpto_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .regs  (regs),
    .take  (take),
    .stage (stage)
  );

  rttpto_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .regs   (regs),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* src/rttpto_chk.sv */
// Port-level checker for the RTT estimator, bound to the top level.
// Depends on rttpto_pkg and rtt_estimator_with_pto_macros.svh.
`default_nettype none
`include "rtt_estimator_with_pto_macros.svh"
module rttpto_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire rttpto_pkg::out_beat_t out_data
);
  import rttpto_pkg::*;

  `RTTPTO_ASSERT_NEXT(a_out_hold, rst_n && out_valid && !out_ready, !rst_n || (out_valid && $stable(out_data)))
  `RTTPTO_ASSERT_NEXT(a_reset_idle, !rst_n, !out_valid)
  `RTTPTO_ASSERT_NOW(a_pto_floor, rst_n && out_valid, out_data.probe_timeout >= PTO_W'(GRANULARITY_US))
  `RTTPTO_ASSERT_NOW(a_pto_covers_srtt, rst_n && out_valid, out_data.probe_timeout > PTO_W'(out_data.srtt))

endmodule

bind rtt_estimator_with_pto rttpto_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
